// ===== rtl/core/bqrs_pkg.sv =====
// Shared types, widths and codes for the biquadratic root solver.
// No dependencies; every module of the solver imports this package.
package bqrs_pkg;

  // Coefficient and fraction widths (Q16.16)
  localparam int COEF_W = 32;
  localparam int FRAC_W = 16;

  // Discriminant magnitude fed to the square root, padded to an even width
  localparam int DISC_W = 66;
  localparam int SDISC_W = DISC_W / 2;

  // Numerator and denominator magnitudes of t = N / M
  localparam int NMAG_W = 34;
  localparam int MMAG_W = 33;

  // Saturated quotient t in Q16.16 and its root
  localparam int TQ_W = 32;
  localparam int TSQ_W = TQ_W + FRAC_W;
  localparam int ROOT_W = TSQ_W / 2;

  // Number of candidate t values
  localparam int NPAIR = 2;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_INF   = 2'd1,
    KIND_ROOTS = 2'd2
  } kind_t;

  // Word context carried alongside the discriminant root
  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic                     a_zero;
    logic                     b_zero;
    logic                     c_zero;
    logic                     d_neg;
    logic                     d_zero;
  } disc_side_t;

  // Word context carried alongside the division and final root
  typedef struct packed {
    kind_t kind;
    logic  v1;
    logic  v2;
  } res_side_t;

endpackage

// ===== rtl/core/bqrs_disc.sv =====
// Two-stage discriminant unit: magnitude products, then D = b*b - 4*a*c.
// Depends on bqrs_pkg.
module bqrs_disc (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [bqrs_pkg::COEF_W-1:0]  in_a,
  input  logic signed [bqrs_pkg::COEF_W-1:0]  in_b,
  input  logic signed [bqrs_pkg::COEF_W-1:0]  in_c,
  output logic                                out_valid,
  output logic        [bqrs_pkg::DISC_W-1:0]  out_dmag,
  output bqrs_pkg::disc_side_t                out_side
);
  import bqrs_pkg::*;

  localparam int PROD_W = 2 * COEF_W;
  localparam int D_W = PROD_W + 3;

  logic [COEF_W-1:0] am, bm, cm;
  logic              v1_r;
  logic [PROD_W-1:0] p_r, b2_r;
  logic              ac_neg_r;
  logic signed [COEF_W-1:0] a1_r, b1_r, c1_r;
  logic [D_W-1:0]    d_nxt, q4, b2e;
  logic              v2_r;
  logic [DISC_W-1:0] dmag_r;
  disc_side_t        side_r, side_nxt;

  // Take magnitudes of the coefficients
  always_comb begin
    am = in_a[COEF_W-1] ? (~in_a + 1'b1) : in_a;
    bm = in_b[COEF_W-1] ? (~in_b + 1'b1) : in_b;
    cm = in_c[COEF_W-1] ? (~in_c + 1'b1) : in_c;
  end

  // Stage one: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r      <= am * cm;
      b2_r     <= bm * bm;
      ac_neg_r <= in_a[COEF_W-1] ^ in_c[COEF_W-1];
      a1_r     <= in_a;
      b1_r     <= in_b;
      c1_r     <= in_c;
    end
  end

  // Stage two: signed discriminant and its flags
  always_comb begin
    q4  = {1'b0, p_r, 2'b00};
    b2e = {3'b000, b2_r};
    d_nxt = ac_neg_r ? (b2e + q4) : (b2e - q4);
    side_nxt.a      = a1_r;
    side_nxt.b      = b1_r;
    side_nxt.c      = c1_r;
    side_nxt.a_zero = (a1_r == '0);
    side_nxt.b_zero = (b1_r == '0);
    side_nxt.c_zero = (c1_r == '0);
    side_nxt.d_neg  = d_nxt[D_W-1];
    side_nxt.d_zero = (d_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dmag_r <= d_nxt[D_W-1] ? '0 : d_nxt[DISC_W-1:0];
      side_r <= side_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_dmag  = dmag_r;
  assign out_side  = side_r;

endmodule

// ===== rtl/core/bqrs_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Several lanes share the stage valid bits and a sideband word. Depends on bqrs_pkg.
module bqrs_sqrt #(
  parameter int IN_W   = bqrs_pkg::DISC_W,
  parameter int LANES  = 1,
  parameter int SIDE_W = $bits(bqrs_pkg::disc_side_t)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [LANES-1:0][IN_W-1:0]         in_x,
  input  logic [SIDE_W-1:0]                  in_side,
  output logic                               out_valid,
  output logic [LANES-1:0][IN_W/2-1:0]       out_root,
  output logic [SIDE_W-1:0]                  out_side
);
  import bqrs_pkg::*;

  localparam int OUT_W = IN_W / 2;
  localparam int RW = OUT_W + 3;

  logic                             vld_r  [OUT_W];
  logic [SIDE_W-1:0]                side_r [OUT_W];
  logic [LANES-1:0][RW-1:0]         rem_r  [OUT_W];
  logic [LANES-1:0][OUT_W-1:0]      root_r [OUT_W];
  logic [LANES-1:0][IN_W-1:0]       x_r    [OUT_W];

  for (genvar s = 0; s < OUT_W; s++) begin : g_stg
    logic                        pv;
    logic [SIDE_W-1:0]           ps;
    logic [LANES-1:0][RW-1:0]    prem, rem_nxt;
    logic [LANES-1:0][OUT_W-1:0] proot, root_nxt;
    logic [LANES-1:0][IN_W-1:0]  px, x_nxt;

    // Select the previous stage, or the input word at the head
    if (s == 0) begin : g_head
      assign pv    = in_valid;
      assign ps    = in_side;
      assign prem  = '0;
      assign proot = '0;
      assign px    = in_x;
    end else begin : g_body
      assign pv    = vld_r[s-1];
      assign ps    = side_r[s-1];
      assign prem  = rem_r[s-1];
      assign proot = root_r[s-1];
      assign px    = x_r[s-1];
    end

    // Bring down two bits, try the next root bit
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RW-1:0] rsh, trial;
      always_comb begin
        rsh   = {prem[l][RW-3:0], px[l][IN_W-1 -: 2]};
        trial = {1'b0, proot[l], 2'b01};
        if (rsh >= trial) begin
          rem_nxt[l]  = rsh - trial;
          root_nxt[l] = {proot[l][OUT_W-2:0], 1'b1};
        end else begin
          rem_nxt[l]  = rsh;
          root_nxt[l] = {proot[l][OUT_W-2:0], 1'b0};
        end
        x_nxt[l] = {px[l][IN_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= ps;
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        x_r[s]    <= x_nxt;
      end
    end
  end

  assign out_valid = vld_r[OUT_W-1];
  assign out_root  = root_r[OUT_W-1];
  assign out_side  = side_r[OUT_W-1];

endmodule

// ===== rtl/core/bqrs_div.sv =====
// Pipelined restoring divider for both t candidates: t = |N| * 2^16 / |M|,
// saturating at all ones, one quotient bit per stage. Depends on bqrs_pkg.
module bqrs_div (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       en,
  input  logic                                       in_valid,
  input  logic [bqrs_pkg::NPAIR-1:0][bqrs_pkg::NMAG_W-1:0] in_nmag,
  input  logic [bqrs_pkg::MMAG_W-1:0]                in_mmag,
  input  bqrs_pkg::res_side_t                        in_side,
  output logic                                       out_valid,
  output logic [bqrs_pkg::NPAIR-1:0][bqrs_pkg::TQ_W-1:0]   out_tq,
  output bqrs_pkg::res_side_t                        out_side
);
  import bqrs_pkg::*;

  localparam int RW = MMAG_W + 1;
  localparam int CMP_W = MMAG_W + FRAC_W;

  // Entry stage
  logic                          ev_r;
  res_side_t                     es_r;
  logic [MMAG_W-1:0]             ed_r;
  logic [NPAIR-1:0][RW-1:0]      erem_r;
  logic [NPAIR-1:0][TQ_W-1:0]    ex_r;
  logic [NPAIR-1:0]              eovf_r;

  // Step stages
  logic                          vld_r  [TQ_W];
  res_side_t                     side_r [TQ_W];
  logic [MMAG_W-1:0]             d_r    [TQ_W];
  logic [NPAIR-1:0][RW-1:0]      rem_r  [TQ_W];
  logic [NPAIR-1:0][TQ_W-1:0]    x_r    [TQ_W];
  logic [NPAIR-1:0][TQ_W-1:0]    q_r    [TQ_W];
  logic [NPAIR-1:0]              ovf_r  [TQ_W];

  // Detect overflow and load the high part of the dividend
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= 1'b0;
    end else if (en) begin
      ev_r <= in_valid;
    end
  end

  for (genvar l = 0; l < NPAIR; l++) begin : g_entry
    always_ff @(posedge clk) begin
      if (en) begin
        eovf_r[l] <= {{(CMP_W-NMAG_W){1'b0}}, in_nmag[l]} >= {in_mmag, {FRAC_W{1'b0}}};
        erem_r[l] <= {{(RW-(NMAG_W-FRAC_W)){1'b0}}, in_nmag[l][NMAG_W-1:FRAC_W]};
        ex_r[l]   <= {in_nmag[l][FRAC_W-1:0], {(TQ_W-FRAC_W){1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      es_r <= in_side;
      ed_r <= in_mmag;
    end
  end

  for (genvar s = 0; s < TQ_W; s++) begin : g_stg
    logic                        pv;
    res_side_t                   ps;
    logic [MMAG_W-1:0]           pd;
    logic [NPAIR-1:0][RW-1:0]    prem, rem_nxt;
    logic [NPAIR-1:0][TQ_W-1:0]  px, x_nxt, pq, q_nxt;
    logic [NPAIR-1:0]            povf;

    if (s == 0) begin : g_head
      assign pv   = ev_r;
      assign ps   = es_r;
      assign pd   = ed_r;
      assign prem = erem_r;
      assign px   = ex_r;
      assign pq   = '0;
      assign povf = eovf_r;
    end else begin : g_body
      assign pv   = vld_r[s-1];
      assign ps   = side_r[s-1];
      assign pd   = d_r[s-1];
      assign prem = rem_r[s-1];
      assign px   = x_r[s-1];
      assign pq   = q_r[s-1];
      assign povf = ovf_r[s-1];
    end

    // Shift in one dividend bit, subtract the divisor where it fits
    for (genvar l = 0; l < NPAIR; l++) begin : g_lane
      logic [RW-1:0] r2, dext;
      always_comb begin
        r2   = {prem[l][RW-2:0], px[l][TQ_W-1]};
        dext = {1'b0, pd};
        if (r2 >= dext) begin
          rem_nxt[l] = r2 - dext;
          q_nxt[l]   = {pq[l][TQ_W-2:0], 1'b1};
        end else begin
          rem_nxt[l] = r2;
          q_nxt[l]   = {pq[l][TQ_W-2:0], 1'b0};
        end
        x_nxt[l] = {px[l][TQ_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= ps;
        d_r[s]    <= pd;
        rem_r[s]  <= rem_nxt;
        x_r[s]    <= x_nxt;
        q_r[s]    <= q_nxt;
        ovf_r[s]  <= povf;
      end
    end
  end

  // Saturate overflowing quotients
  for (genvar l = 0; l < NPAIR; l++) begin : g_out
    assign out_tq[l] = ovf_r[TQ_W-1][l] ? {TQ_W{1'b1}} : q_r[TQ_W-1][l];
  end

  assign out_valid = vld_r[TQ_W-1];
  assign out_side  = side_r[TQ_W-1];

endmodule

// ===== rtl/core/biquadratic_root_solver.sv =====
// Channel | ports                                                   | direction
// in      | in_valid, in_stall, in_coef_quartic/square/constant     | coefficients in
// out     | out_valid, out_stall, out_solution_kind, out_*_pair_valid, out_*_root | roots out
//
// One word is taken every cycle while in_stall is low; each word passes in order through
// discriminant, discriminant root, numerator set-up, divider and final root.
// All stages advance together whenever the output register is empty or taken;
// in_stall is raised only while a finished word waits under out_stall.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// Depends on bqrs_pkg, bqrs_disc, bqrs_sqrt and bqrs_div.
module biquadratic_root_solver (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [bqrs_pkg::COEF_W-1:0]  in_coef_quartic,
  input  logic signed [bqrs_pkg::COEF_W-1:0]  in_coef_square,
  input  logic signed [bqrs_pkg::COEF_W-1:0]  in_coef_constant,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_solution_kind,
  output logic                                out_first_pair_valid,
  output logic [bqrs_pkg::TQ_W-1:0]           out_first_root,
  output logic                                out_second_pair_valid,
  output logic [bqrs_pkg::TQ_W-1:0]           out_second_root
);
  import bqrs_pkg::*;

  localparam int N_W = NMAG_W + 1;
  localparam int M_W = MMAG_W + 1;

  logic                          en;
  logic                          dv;
  logic [DISC_W-1:0]             dmag;
  disc_side_t                    dside;
  logic                          sv;
  logic [0:0][SDISC_W-1:0]       sroot;
  logic [$bits(disc_side_t)-1:0] sside_raw;
  disc_side_t                    sside;

  logic signed [N_W-1:0]         bneg, cneg, sroot_e, n1, n2;
  logic signed [M_W-1:0]         m;
  logic [NPAIR-1:0][NMAG_W-1:0]  nmag_nxt;
  logic [MMAG_W-1:0]             mmag_nxt;
  logic                          used1, used2, ok1, ok2;
  res_side_t                     pside_nxt;

  logic                          pv_r;
  logic [NPAIR-1:0][NMAG_W-1:0]  pnmag_r;
  logic [MMAG_W-1:0]             pmmag_r;
  res_side_t                     pside_r;

  logic                          qv;
  logic [NPAIR-1:0][TQ_W-1:0]    tq;
  res_side_t                     qside;
  logic [NPAIR-1:0][TSQ_W-1:0]   tsq;
  logic                          rv;
  logic [NPAIR-1:0][ROOT_W-1:0]  rroot;
  logic [$bits(res_side_t)-1:0]  rside_raw;
  res_side_t                     rside;

  // Advance all stages unless a finished word is held
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  bqrs_disc u_disc (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_a     (in_coef_quartic),
    .in_b     (in_coef_square),
    .in_c     (in_coef_constant),
    .out_valid(dv),
    .out_dmag (dmag),
    .out_side (dside)
  );

  bqrs_sqrt #(
    .IN_W  (DISC_W),
    .LANES (1),
    .SIDE_W($bits(disc_side_t))
  ) u_dsqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (dv),
    .in_x     (dmag),
    .in_side  (dside),
    .out_valid(sv),
    .out_root (sroot),
    .out_side (sside_raw)
  );

  assign sside = disc_side_t'(sside_raw);

  // Form numerators, denominator, validity and kind
  always_comb begin
    bneg    = -N_W'(sside.b);
    cneg    = -N_W'(sside.c);
    sroot_e = N_W'(sroot[0]);
    n1      = sside.a_zero ? cneg : (bneg + sroot_e);
    n2      = bneg - sroot_e;
    m       = sside.a_zero ? M_W'(sside.b) : {sside.a[COEF_W-1], sside.a, 1'b0};
    used1   = sside.a_zero ? !sside.b_zero : !sside.d_neg;
    used2   = !sside.a_zero && !sside.d_neg && !sside.d_zero;
    ok1     = used1 && ((n1 == '0) || (n1[N_W-1] == m[M_W-1]));
    ok2     = used2 && ((n2 == '0) || (n2[N_W-1] == m[M_W-1]));
    nmag_nxt[0] = n1[N_W-1] ? NMAG_W'(-n1) : NMAG_W'(n1);
    nmag_nxt[1] = n2[N_W-1] ? NMAG_W'(-n2) : NMAG_W'(n2);
    mmag_nxt    = m[M_W-1] ? MMAG_W'(-m) : MMAG_W'(m);
    pside_nxt.v1 = ok1;
    pside_nxt.v2 = ok2;
    if (sside.a_zero && sside.b_zero) begin
      pside_nxt.kind = sside.c_zero ? KIND_INF : KIND_NONE;
    end else begin
      pside_nxt.kind = (ok1 || ok2) ? KIND_ROOTS : KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pnmag_r <= nmag_nxt;
      pmmag_r <= mmag_nxt;
      pside_r <= pside_nxt;
    end
  end

  bqrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (pv_r),
    .in_nmag  (pnmag_r),
    .in_mmag  (pmmag_r),
    .in_side  (pside_r),
    .out_valid(qv),
    .out_tq   (tq),
    .out_side (qside)
  );

  // Scale t by 2^16 before its root
  for (genvar l = 0; l < NPAIR; l++) begin : g_tsq
    assign tsq[l] = {tq[l], {FRAC_W{1'b0}}};
  end

  bqrs_sqrt #(
    .IN_W  (TSQ_W),
    .LANES (NPAIR),
    .SIDE_W($bits(res_side_t))
  ) u_tsqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (qv),
    .in_x     (tsq),
    .in_side  (qside),
    .out_valid(rv),
    .out_root (rroot),
    .out_side (rside_raw)
  );

  assign rside = res_side_t'(rside_raw);

  // Drive the result word, zeroing unused roots
  assign out_valid             = rv;
  assign out_solution_kind     = rside.kind;
  assign out_first_pair_valid  = rside.v1;
  assign out_second_pair_valid = rside.v2;
  assign out_first_root  = rside.v1 ? TQ_W'(rroot[0]) : '0;
  assign out_second_root = rside.v2 ? TQ_W'(rroot[1]) : '0;

  a_inf_no_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_solution_kind == KIND_INF) |->
      !out_first_pair_valid && !out_second_pair_valid)
    else $error("infinite-solution word carries a valid pair");

  a_roots_have_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_solution_kind == KIND_ROOTS) |->
      out_first_pair_valid || out_second_pair_valid)
    else $error("root word without a valid pair");

  a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while the result word is held");

endmodule
